FILE: hw/rtl/scroll_address_register_unit_core_defines.svh
// Assertion macros shared by the scroll and address register unit.
`ifndef SCROLL_ADDRESS_REGISTER_UNIT_CORE_DEFINES_SVH
`define SCROLL_ADDRESS_REGISTER_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SARU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saru assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SARU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saru assertion failed");

`endif

FILE: hw/rtl/saru_pkg.sv
// Package: types, codes and constants of the scroll and address register unit.
`timescale 1ns / 1ps
package saru_pkg;

    localparam int DOTS_PER_LINE_DEF   = 341;
    localparam int LINES_PER_FRAME_DEF = 262;

    localparam int VADDR_W = 15;
    localparam int FADDR_W = 14;
    localparam int CNT_W   = 9;

    localparam logic [CNT_W-1:0] LINE_RESET = 9'd261;

    localparam logic [FADDR_W-1:0] NT_BASE = 14'h2000;
    localparam logic [FADDR_W-1:0] AT_BASE = 14'h23C0;

    typedef enum logic [2:0] {
        KIND_CTRL_WR   = 3'd0,
        KIND_SCROLL_WR = 3'd1,
        KIND_ADDR_WR   = 3'd2,
        KIND_STATUS_WR = 3'd3,
        KIND_STATUS_RD = 3'd4,
        KIND_TICK      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        FETCH_NT     = 2'd0,
        FETCH_ATTR   = 2'd1,
        FETCH_PAT_LO = 2'd2,
        FETCH_PAT_HI = 2'd3
    } fetch_sel_t;

    // Inputs to the fetch address generator
    typedef struct packed {
        logic [VADDR_W-1:0] vaddr;
        logic               bg_table;  // control bit 4
        fetch_sel_t         sel;
        logic [7:0]         tile;
    } fetch_req_t;

endpackage

FILE: hw/rtl/saru_fetch_gen.sv
// Fetch address generator: nametable, attribute and pattern addresses from v.
`timescale 1ns / 1ps
module saru_fetch_gen
    import saru_pkg::*;
(
    input  fetch_req_t           req,
    output logic [FADDR_W-1:0]   fetch_address
);

    logic [FADDR_W-1:0] pat_addr;

    // bit 12 table select, bits 11:4 tile, bit 3 plane, bits 2:0 fine Y
    assign pat_addr = {1'b0, req.bg_table, req.tile, 1'b0, req.vaddr[14:12]};

    always_comb
    begin
        unique case (req.sel)
            FETCH_NT:
                fetch_address = NT_BASE | {2'b00, req.vaddr[11:0]};
            FETCH_ATTR:
                fetch_address = AT_BASE | {2'b00, req.vaddr[11:10], 4'b0000,
                                           req.vaddr[9:7], req.vaddr[4:2]};
            FETCH_PAT_LO:
                fetch_address = pat_addr;
            FETCH_PAT_HI:
                fetch_address = pat_addr | 14'h0008;
            default:
                fetch_address = pat_addr;
        endcase
    end

endmodule

FILE: hw/rtl/scroll_address_register_unit_core.sv
// Scroll and address register unit: loopy t/v registers, fine X, toggle, dot counters.
// The result beat for an item is registered and appears in the cycle after the item's input beat.
// Throughput: one item per cycle unless m_tready stalls; state update and fetch address
//   logic sit between the input handshake and one output register, refilled as it drains.
// Reset (rst_n low, asynchronous): all address, toggle, control and status state
//   cleared, dot counter 0, scanline counter 261, output register empty.
`timescale 1ns / 1ps
`include "scroll_address_register_unit_core_defines.svh"
module scroll_address_register_unit_core
    import saru_pkg::*;
#(
    parameter int DOTS_PER_LINE   = DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data[7:0], fetch_select[9:8], tile_number[17:10], zero
    input  logic [2:0]  s_tuser,   // kind[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // fetch_address[13:0], read_data[21:14],
                                   // fine_scroll_x[24:22], vram_address[39:25],
                                   // dot_count[48:40], scanline_count[57:49],
                                   // write_toggle[58], zero
);

    localparam logic [CNT_W:0] DOT_LIM  = (CNT_W+1)'(DOTS_PER_LINE);
    localparam logic [CNT_W:0] LINE_LIM = (CNT_W+1)'(LINES_PER_FRAME);

    // ---------------------------------------------------------------
    // Beat decode
    // ---------------------------------------------------------------
    logic       accept;
    kind_t      kind;
    logic [7:0] wdata;
    fetch_sel_t fsel;
    logic [7:0] tile;

    assign accept = s_tvalid & s_tready;
    assign kind   = kind_t'(s_tuser);
    assign wdata  = s_tdata[7:0];
    assign fsel   = fetch_sel_t'(s_tdata[9:8]);
    assign tile   = s_tdata[17:10];

    // ---------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------
    logic [VADDR_W-1:0] t_reg,      t_next;
    logic [VADDR_W-1:0] v_reg,      v_next;
    logic [2:0]         fine_x_reg, fine_x_next;
    logic               toggle_reg, toggle_next;
    logic [7:0]         ctrl_reg,   ctrl_next;
    logic [7:0]         status_reg, status_next;
    logic [CNT_W-1:0]   dot_reg,    dot_next;
    logic [CNT_W-1:0]   line_reg,   line_next;
    logic [7:0]         rd_data;

    logic [CNT_W:0]     dot_inc;
    logic [CNT_W:0]     line_inc;

    assign dot_inc  = {1'b0, dot_reg} + 1'b1;
    assign line_inc = {1'b0, line_reg} + 1'b1;

    always_comb
    begin
        t_next      = t_reg;
        v_next      = v_reg;
        fine_x_next = fine_x_reg;
        toggle_next = toggle_reg;
        ctrl_next   = ctrl_reg;
        status_next = status_reg;
        dot_next    = dot_reg;
        line_next   = line_reg;
        rd_data     = 8'h00;

        unique case (kind)
            KIND_CTRL_WR:
            begin
                ctrl_next          = wdata;
                t_next[11:10]      = wdata[1:0];
            end
            KIND_SCROLL_WR:
            begin
                if (!toggle_reg)
                begin
                    // coarse X and fine X
                    fine_x_next = wdata[2:0];
                    t_next[4:0] = wdata[7:3];
                end
                else
                begin
                    // fine Y and coarse Y
                    t_next[14:12] = wdata[2:0];
                    t_next[9:5]   = wdata[7:3];
                end
                toggle_next = ~toggle_reg;
            end
            KIND_ADDR_WR:
            begin
                if (!toggle_reg)
                begin
                    t_next[14]   = 1'b0;
                    t_next[13:8] = wdata[5:0];
                end
                else
                begin
                    t_next[7:0] = wdata;
                    v_next      = {t_reg[14:8], wdata};
                end
                toggle_next = ~toggle_reg;
            end
            KIND_STATUS_WR:
                status_next = wdata;
            KIND_STATUS_RD:
            begin
                rd_data     = status_reg;
                toggle_next = 1'b0;
            end
            KIND_TICK:
            begin
                if (dot_inc >= DOT_LIM)
                begin
                    dot_next = '0;
                    if (line_inc >= LINE_LIM)
                        line_next = '0;
                    else
                        line_next = line_inc[CNT_W-1:0];
                end
                else
                begin
                    dot_next = dot_inc[CNT_W-1:0];
                end
            end
            default:
            begin
                // unused kinds leave the state alone
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Fetch address from the post-item state
    // ---------------------------------------------------------------
    fetch_req_t         freq;
    logic [FADDR_W-1:0] faddr;

    assign freq.vaddr    = v_next;
    assign freq.bg_table = ctrl_next[4];
    assign freq.sel      = fsel;
    assign freq.tile     = tile;

    saru_fetch_gen u_fetch_gen
    (
        .req           (freq),
        .fetch_address (faddr)
    );

    // ---------------------------------------------------------------
    // Output register; input stays open while it drains
    // ---------------------------------------------------------------
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg,  m_data_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {5'b00000, toggle_next, line_next, dot_next, v_next,
                            fine_x_next, rd_data, faddr};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg       <= '0;
            v_reg       <= '0;
            fine_x_reg  <= '0;
            toggle_reg  <= 1'b0;
            ctrl_reg    <= '0;
            status_reg  <= '0;
            dot_reg     <= '0;
            line_reg    <= LINE_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                t_reg      <= t_next;
                v_reg      <= v_next;
                fine_x_reg <= fine_x_next;
                toggle_reg <= toggle_next;
                ctrl_reg   <= ctrl_next;
                status_reg <= status_next;
                dot_reg    <= dot_next;
                line_reg   <= line_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SARU_ASSERT_NOW(a_dot_in_range, clk, rst_n, 1'b1, {1'b0, dot_reg} < DOT_LIM)
    `SARU_ASSERT_NEXT(a_rd_clears_toggle, clk, rst_n,
        accept && kind == KIND_STATUS_RD, !toggle_reg)
    `SARU_ASSERT_NEXT(a_addr2_copies_t, clk, rst_n,
        accept && kind == KIND_ADDR_WR && toggle_reg, v_reg == t_reg && !toggle_reg)
    `SARU_ASSERT_NEXT(a_beat_reaches_out, clk, rst_n,
        accept, m_tvalid && m_tdata[39:25] == v_reg)

endmodule

FILE: tb/scroll_register_checker.sv
// Checker for the scroll and address register unit: predicts and compares result beats.
`timescale 1ns / 1ps
module scroll_register_checker
    import saru_pkg::*;
#(
    parameter int DOTS_PER_LINE   = DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // data[7:0], fetch_select[9:8], tile_number[17:10], zero
    input  logic [2:0]  s_tuser,   // kind[2:0]

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // fetch_address, read_data, fine_scroll_x, vram_address,
                                   // dot_count, scanline_count, write_toggle, zero

    output int          mismatches,
    output int          in_flight
);

    typedef struct {
        logic [FADDR_W-1:0] fetch_address;
        logic [7:0]         read_data;
        logic [2:0]         fine_scroll_x;
        logic [VADDR_W-1:0] vram_address;
        logic [CNT_W-1:0]   dot_count;
        logic [CNT_W-1:0]   scanline_count;
        logic               write_toggle;
    } reg_view_t;

    // Model copy of the unit's state
    logic [VADDR_W-1:0] t_addr;
    logic [VADDR_W-1:0] v_addr;
    logic [2:0]         fine_x;
    logic               toggle;
    logic [7:0]         ctrl_reg;
    logic [7:0]         status_reg;
    logic [CNT_W-1:0]   dot_pos;
    logic [CNT_W-1:0]   line_pos;

    reg_view_t expected_views[$];
    reg_view_t want;

    // Applies one access or tick, then reports the view after it.
    function automatic reg_view_t step_scroll_regs(input logic [2:0] kind, input logic [7:0] data,
                                                   input logic [1:0] sel, input logic [7:0] tile);
        reg_view_t view;
        view.read_data = 8'h00;
        case (kind)
            KIND_CTRL_WR: begin
                ctrl_reg       = data;
                t_addr[11:10]  = data[1:0];
            end
            KIND_SCROLL_WR: begin
                if (!toggle) begin
                    fine_x      = data[2:0];
                    t_addr[4:0] = data[7:3];
                end
                else begin
                    t_addr[14:12] = data[2:0];
                    t_addr[9:5]   = data[7:3];
                end
                toggle = ~toggle;
            end
            KIND_ADDR_WR: begin
                if (!toggle) begin
                    t_addr[14]   = 1'b0;
                    t_addr[13:8] = data[5:0];
                end
                else begin
                    t_addr[7:0] = data;
                    v_addr      = t_addr;
                end
                toggle = ~toggle;
            end
            KIND_STATUS_WR: status_reg = data;
            KIND_STATUS_RD: begin
                view.read_data = status_reg;
                toggle         = 1'b0;
            end
            KIND_TICK: begin
                if (int'(dot_pos) + 1 >= DOTS_PER_LINE) begin
                    dot_pos = '0;
                    if (int'(line_pos) + 1 >= LINES_PER_FRAME)
                        line_pos = '0;
                    else
                        line_pos = line_pos + 1'b1;
                end
                else begin
                    dot_pos = dot_pos + 1'b1;
                end
            end
            default: ;  // spare kinds leave the state alone
        endcase

        case (sel)
            FETCH_NT:   view.fetch_address = NT_BASE | {2'b00, v_addr[11:0]};
            FETCH_ATTR: view.fetch_address = AT_BASE | {2'b00, v_addr[11:10], 4'b0000,
                                                        v_addr[9:7], v_addr[4:2]};
            default:    view.fetch_address = {1'b0, ctrl_reg[4], tile, sel == FETCH_PAT_HI,
                                              v_addr[14:12]};
        endcase
        view.fine_scroll_x  = fine_x;
        view.vram_address   = v_addr;
        view.dot_count      = dot_pos;
        view.scanline_count = line_pos;
        view.write_toggle   = toggle;
        return view;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            t_addr     = '0;
            v_addr     = '0;
            fine_x     = '0;
            toggle     = 1'b0;
            ctrl_reg   = '0;
            status_reg = '0;
            dot_pos    = '0;
            line_pos   = LINE_RESET;
            mismatches = 0;
            expected_views.delete();
            in_flight <= 0;
        end
        else begin
            // result side first: results are registered, so the item behind a result beat is already queued
            if (m_tvalid && m_tready) begin
                if (expected_views.size() == 0) begin
                    $error("result beat with no item waiting");
                    mismatches++;
                end
                else begin
                    want = expected_views.pop_front();
                    check_field("fetch_address",  want.fetch_address,  m_tdata[13:0]);
                    check_field("read_data",      want.read_data,      m_tdata[21:14]);
                    check_field("fine_scroll_x",  want.fine_scroll_x,  m_tdata[24:22]);
                    check_field("vram_address",   want.vram_address,   m_tdata[39:25]);
                    check_field("dot_count",      want.dot_count,      m_tdata[48:40]);
                    check_field("scanline_count", want.scanline_count, m_tdata[57:49]);
                    check_field("write_toggle",   want.write_toggle,   m_tdata[58]);
                    check_field("padding",        0,                   m_tdata[63:59]);
                end
            end
            if (s_tvalid && s_tready)
                expected_views.push_back(step_scroll_regs(s_tuser, s_tdata[7:0],
                                                          s_tdata[9:8], s_tdata[17:10]));
            in_flight <= expected_views.size();
        end
    end

endmodule

FILE: tb/tb_scroll_address_register_unit_core.sv
// Testbench top for the scroll and address register unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_scroll_address_register_unit_core;
    import saru_pkg::*;

    // Kinds the unit decodes as no-ops
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 540;
    localparam int HOLD_AT      = 150;   // random beat count where the long result stall starts
    localparam int DRAIN_AT     = 300;   // sender stops here until every result is back
    localparam int QUIET_AT     = 440;   // no idling on either side from here on
    localparam int LONG_HOLD    = 300;   // cycles of the long result stall
    localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
    localparam int TICK_RUN     = 2 * DOTS_PER_LINE_DEF + 2;

    // Opening accesses: {kind, data}. Walks both halves of the scroll and address
    // writes, toggle clearing by a status read, bit 14 of v set through a scroll
    // write and cleared by a first address write, status round trips, spare kinds.
    localparam logic [10:0] OPENING [0:22] = '{
        {KIND_CTRL_WR,   8'hFF},
        {KIND_CTRL_WR,   8'h00},
        {KIND_SCROLL_WR, 8'hFF},   // first half
        {KIND_SCROLL_WR, 8'hFF},   // second half
        {KIND_SCROLL_WR, 8'hA5},   // first half, then toggle cleared
        {KIND_STATUS_RD, 8'h00},
        {KIND_SCROLL_WR, 8'h00},
        {KIND_SCROLL_WR, 8'h00},
        {KIND_ADDR_WR,   8'hFF},   // first half drops t bit 14
        {KIND_ADDR_WR,   8'hFF},   // second half copies t to v
        {KIND_SCROLL_WR, 8'h3A},
        {KIND_SCROLL_WR, 8'hFF},   // fine Y = 7 puts t bit 14 high
        {KIND_SCROLL_WR, 8'h00},   // toggle now set
        {KIND_ADDR_WR,   8'hC3},   // second half: v picks up bit 14
        {KIND_ADDR_WR,   8'h00},
        {KIND_ADDR_WR,   8'h00},
        {KIND_STATUS_WR, 8'hFF},
        {KIND_STATUS_RD, 8'h00},
        {KIND_STATUS_WR, 8'h00},
        {KIND_STATUS_RD, 8'h00},
        {KIND_CTRL_WR,   8'h13},   // background pattern table 1
        {KIND_SPARE_6,   8'hFF},
        {KIND_SPARE_7,   8'h55}
    };

    logic        clk = 1'b0;
    logic        rst_n;

    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // data[7:0], fetch_select[9:8], tile_number[17:10], zero
    logic [2:0]  s_tuser;    // kind[2:0]

    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // fetch_address[13:0], read_data[21:14], fine_scroll_x[24:22],
                             // vram_address[39:25], dot_count[48:40],
                             // scanline_count[57:49], write_toggle[58], zero

    int          mismatches;
    int          in_flight;
    int          beats_sent  = 0;
    int          idle_cycles = 0;
    int          random_start;
    int          random_done;
    int          pick;
    bit          drained = 1'b0;
    logic        quiet;       // no idling on either side
    logic        hold_armed;  // asks the receiver for its long stall

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    scroll_address_register_unit_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scroll_register_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    // Offers one beat, maybe after a short idle burst, and returns at the edge
    // that accepts it. Valid stays high into the next call unless that call idles.
    task automatic push_access(input logic [2:0] kind, input logic [7:0] data,
                               input logic [1:0] sel, input logic [7:0] tile);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, tile, sel, data};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    // Random fetch select and tile for everything past the opening accesses
    task automatic push_random(input logic [2:0] kind, input logic [7:0] data);
        push_access(kind, data, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // Receiver: short stall bursts, ready stretches, and one long hold-off on request
    initial
    begin
        bit hold_served;
        hold_served = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_armed && !hold_served) begin
                // long stall: output register fills, input side backs up
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Watchdog: any beat on either side restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        quiet      <= 1'b0;
        hold_armed <= 1'b0;
        rst_n      <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening accesses: fetch select cycles through all four, tile flips between extremes
        for (int i = 0; i < $size(OPENING); i++)
            push_access(OPENING[i][10:8], OPENING[i][7:0], 2'(i % 4),
                        (i % 2) ? 8'hFF : 8'h00);

        // Two full scanlines of ticks: the first wrap also takes line 261 around to 0
        repeat (TICK_RUN) push_random(KIND_TICK, 8'($urandom_range(0, 255)));

        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_ITEMS)
        begin
            random_done = beats_sent - random_start;
            if (random_done >= HOLD_AT)
                hold_armed <= 1'b1;
            if (random_done >= QUIET_AT)
                quiet <= 1'b1;
            if (!drained && random_done >= DRAIN_AT) begin
                // sender pause until every result is back
                s_tvalid <= 1'b0;
                do @(posedge clk); while (in_flight != 0);
                drained = 1'b1;
            end

            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                // well-formed register sequences with random content
                if ($urandom_range(0, 1))
                    push_random(KIND_STATUS_RD, 8'($urandom_range(0, 255)));
                case ($urandom_range(0, 4))
                    0: repeat (2) push_random(KIND_SCROLL_WR, 8'($urandom_range(0, 255)));
                    1: repeat (2) push_random(KIND_ADDR_WR, 8'($urandom_range(0, 255)));
                    2: begin
                        push_random(KIND_CTRL_WR, 8'($urandom_range(0, 255)));
                        repeat (2) push_random(KIND_SCROLL_WR, 8'($urandom_range(0, 255)));
                        repeat (2) push_random(KIND_ADDR_WR, 8'($urandom_range(0, 255)));
                    end
                    3: push_random(KIND_CTRL_WR, 8'($urandom_range(0, 255)));
                    default: begin
                        push_random(KIND_STATUS_WR, 8'($urandom_range(0, 255)));
                        push_random(KIND_STATUS_RD, 8'($urandom_range(0, 255)));
                    end
                endcase
            end
            else if (pick < 8) begin
                // noise: any kind, spare ones included
                push_random(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            else if (pick == 8) begin
                repeat ($urandom_range(1, 40))
                    push_random(KIND_TICK, 8'($urandom_range(0, 255)));
            end
            else begin
                // broken sequence: a single scroll or address write, then the toggle is cleared
                push_random($urandom_range(0, 1) ? KIND_SCROLL_WR : KIND_ADDR_WR,
                            8'($urandom_range(0, 255)));
                push_random(KIND_STATUS_RD, 8'($urandom_range(0, 255)));
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/saru_pkg.sv
hw/rtl/saru_fetch_gen.sv
hw/rtl/scroll_address_register_unit_core.sv
tb/scroll_register_checker.sv
tb/tb_scroll_address_register_unit_core.sv
